[rtl/ssa_pkg.sv]
// types, constants and codes shared by the slab slot allocator modules
package ssa_pkg;

   localparam int SLABS   = 8;
   localparam int SLOTS   = 64;
   localparam int SLAB_W  = 3;
   localparam int SLOT_W  = 6;
   localparam int CNT_W   = 7;
   localparam int REC_W   = 3;
   localparam int TOTAL_W = 10;
   localparam int SIZE_W  = 13;
   localparam int OFF_W   = 18;
   localparam int PROD_W  = 19;
   localparam int ADDR_W  = SLAB_W + SLOT_W;
   localparam int QDEPTH  = 2;

   localparam logic [OFF_W-1:0]  OFF_MAX       = 18'h3FFFF;
   localparam logic [CNT_W-1:0]  SLOTS_MAX     = 7'd64;
   localparam logic [CNT_W-1:0]  RESET_SLOTS   = 7'd64;
   localparam logic [SIZE_W-1:0] RESET_OBJSIZE = 13'd64;

   localparam logic CSR_SLOTS_PER_SLAB = 1'b0;
   localparam logic CSR_OBJECT_SIZE    = 1'b1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SLAB  = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [SLAB_W-1:0] slab;
      logic [SLOT_W-1:0] slot;
   } item_type;

   typedef struct packed {
      logic in_use;
      logic [SLOT_W-1:0] link;
   } entry_type;

endpackage

[rtl/ssa_front.sv]
// request intake: classifies each item and queues it for the back end
module ssa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,
   input  logic                   req_tuser,
   output logic                   q_valid,
   input  logic                   q_pop,
   output ssa_pkg::item_type      q_item
);

   ssa_pkg::item_type q_mem_ff [ssa_pkg::QDEPTH];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   ssa_pkg::item_type cls;
   logic push;
   logic pop;

   always_comb begin
      cls.op   = req_tuser ? ssa_pkg::OP_FREE : ssa_pkg::OP_ALLOC;
      cls.slab = req_tdata[ssa_pkg::SLAB_W-1:0];
      cls.slot = req_tdata[ssa_pkg::SLAB_W +: ssa_pkg::SLOT_W];
   end

   assign req_tready = (count_ff != 2'(ssa_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[rtl/ssa_back.sv]
// allocation engine: slab choice, free-list memory and bookkeeping
module ssa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [12:0]               csr_wdata,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  ssa_pkg::item_type         q_item,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   localparam int SN = ssa_pkg::SLABS;
   localparam int AW = ssa_pkg::ADDR_W;

   ssa_pkg::state_type state_ff, state_in;
   ssa_pkg::item_type item_ff, item_in;
   logic [ssa_pkg::SLAB_W-1:0] sel_ff, sel_in;
   logic fail_ff, fail_in;

   logic active_ff [SN];
   logic active_in [SN];
   logic partial_ff [SN];
   logic partial_in [SN];
   logic [ssa_pkg::REC_W-1:0] rec_ff [SN];
   logic [ssa_pkg::REC_W-1:0] rec_in [SN];
   logic [ssa_pkg::SLOT_W-1:0] head_ff [SN];
   logic [ssa_pkg::SLOT_W-1:0] head_in [SN];
   logic [ssa_pkg::CNT_W-1:0] fc_ff [SN];
   logic [ssa_pkg::CNT_W-1:0] fc_in [SN];
   logic [ssa_pkg::CNT_W-1:0] size_ff [SN];
   logic [ssa_pkg::CNT_W-1:0] size_in [SN];
   logic [ssa_pkg::CNT_W-1:0] fresh_ff [SN];
   logic [ssa_pkg::CNT_W-1:0] fresh_in [SN];
   logic cur_valid_ff, cur_valid_in;
   logic [ssa_pkg::SLAB_W-1:0] cur_ff, cur_in;
   logic [ssa_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [ssa_pkg::CNT_W-1:0] spp_ff;
   logic [ssa_pkg::SIZE_W-1:0] osize_ff;

   ssa_pkg::entry_type mem [1 << AW];
   ssa_pkg::entry_type rd_ff;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   ssa_pkg::entry_type wr_data;

   logic rsp_valid_ff, rsp_valid_in;
   ssa_pkg::status_type status_ff, status_in;
   logic [ssa_pkg::SLAB_W-1:0] oslab_ff, oslab_in;
   logic [ssa_pkg::SLOT_W-1:0] oslot_ff, oslot_in;
   logic [ssa_pkg::OFF_W-1:0] off_ff, off_in;

   logic have_free;
   logic [ssa_pkg::SLAB_W-1:0] open_idx;
   logic part_found;
   logic [ssa_pkg::SLAB_W-1:0] part_idx;
   logic empty_found;
   logic [ssa_pkg::SLAB_W-1:0] empty_idx;
   logic cur_ok;
   logic [ssa_pkg::CNT_W-1:0] n_open;
   logic [ssa_pkg::PROD_W-1:0] prod;

   // slab choice from the registered bookkeeping
   always_comb begin
      have_free   = 1'b0;
      open_idx    = '0;
      part_found  = 1'b0;
      part_idx    = '0;
      empty_found = 1'b0;
      empty_idx   = '0;
      for (int s = 0; s < SN; s++) begin
         if (!active_ff[s] && !have_free) begin
            have_free = 1'b1;
            open_idx  = ssa_pkg::SLAB_W'(s);
         end
         if (partial_ff[s] && active_ff[s] && fc_ff[s] != '0 &&
             (!part_found || rec_ff[s] < rec_ff[part_idx])) begin
            part_found = 1'b1;
            part_idx   = ssa_pkg::SLAB_W'(s);
         end
         if (active_ff[s] && fc_ff[s] == size_ff[s] && fc_ff[s] != '0 && !empty_found) begin
            empty_found = 1'b1;
            empty_idx   = ssa_pkg::SLAB_W'(s);
         end
      end
      cur_ok = cur_valid_ff && active_ff[cur_ff] && fc_ff[cur_ff] != '0;
      if (spp_ff == '0) begin
         n_open = ssa_pkg::CNT_W'(1);
      end else if (spp_ff > ssa_pkg::SLOTS_MAX) begin
         n_open = ssa_pkg::SLOTS_MAX;
      end else begin
         n_open = spp_ff;
      end
   end

   always_comb begin
      logic [ssa_pkg::SLAB_W-1:0] s;
      logic [ssa_pkg::SLOT_W-1:0] slot;
      logic [ssa_pkg::CNT_W-1:0] fc;
      logic [ssa_pkg::CNT_W-1:0] fc_new;
      logic fresh_slot;
      logic good;
      logic other_empty;

      state_in     = state_ff;
      item_in      = item_ff;
      sel_in       = sel_ff;
      fail_in      = fail_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      total_in     = total_ff;
      for (int t = 0; t < SN; t++) begin
         active_in[t]  = active_ff[t];
         partial_in[t] = partial_ff[t];
         rec_in[t]     = rec_ff[t];
         head_in[t]    = head_ff[t];
         fc_in[t]      = fc_ff[t];
         size_in[t]    = size_ff[t];
         fresh_in[t]   = fresh_ff[t];
      end
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {sel_ff, (item_ff.op == ssa_pkg::OP_ALLOC) ? head_ff[sel_ff] : item_ff.slot};
      wr_en        = 1'b0;
      wr_addr      = {sel_ff, item_ff.slot};
      wr_data      = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      oslab_in     = oslab_ff;
      oslot_in     = oslot_ff;
      off_in       = off_ff;
      s            = sel_ff;
      slot         = head_ff[sel_ff];
      fc           = fc_ff[sel_ff];
      fc_new       = fc;
      fresh_slot   = 1'b0;
      good         = 1'b0;
      other_empty  = 1'b0;
      prod         = ssa_pkg::PROD_W'(head_ff[sel_ff]) * ssa_pkg::PROD_W'(osize_ff);

      unique case (state_ff)
         ssa_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               fail_in  = 1'b0;
               state_in = ssa_pkg::S_READ;
               if (q_item.op == ssa_pkg::OP_FREE) begin
                  sel_in = q_item.slab;
               end else if (total_ff == '0) begin
                  if (have_free) begin
                     sel_in               = open_idx;
                     active_in[open_idx]  = 1'b1;
                     size_in[open_idx]    = n_open;
                     fc_in[open_idx]      = n_open;
                     fresh_in[open_idx]   = '0;
                     head_in[open_idx]    = '0;
                     partial_in[open_idx] = 1'b0;
                     rec_in[open_idx]     = '0;
                     total_in             = total_ff + ssa_pkg::TOTAL_W'(n_open);
                     cur_valid_in         = 1'b1;
                     cur_in               = open_idx;
                  end else begin
                     fail_in = 1'b1;
                  end
               end else if (cur_ok) begin
                  sel_in = cur_ff;
               end else if (part_found) begin
                  sel_in       = part_idx;
                  cur_valid_in = 1'b1;
                  cur_in       = part_idx;
               end else if (empty_found) begin
                  sel_in       = empty_idx;
                  cur_valid_in = 1'b1;
                  cur_in       = empty_idx;
               end else begin
                  fail_in = 1'b1;
               end
            end
         end
         ssa_pkg::S_READ: begin
            rd_en    = 1'b1;
            state_in = ssa_pkg::S_EXEC;
         end
         ssa_pkg::S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = ssa_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               oslab_in     = '0;
               oslot_in     = '0;
               off_in       = '0;
               if (item_ff.op == ssa_pkg::OP_ALLOC) begin
                  if (fail_ff) begin
                     status_in = ssa_pkg::ST_NO_SLAB;
                  end else begin
                     status_in  = ssa_pkg::ST_OK;
                     fresh_slot = ({1'b0, slot} >= fresh_ff[s]);
                     if (fc == size_ff[s] && fc > ssa_pkg::CNT_W'(1)) begin
                        for (int t = 0; t < SN; t++) begin
                           if (partial_ff[t] && ssa_pkg::SLAB_W'(t) != s) begin
                              rec_in[t] = rec_ff[t] + ssa_pkg::REC_W'(1);
                           end
                        end
                        partial_in[s] = 1'b1;
                        rec_in[s]     = '0;
                     end
                     head_in[s] = fresh_slot ? slot + ssa_pkg::SLOT_W'(1) : rd_ff.link;
                     if (fresh_slot) begin
                        fresh_in[s] = {1'b0, slot} + ssa_pkg::CNT_W'(1);
                     end
                     fc_new   = fc - ssa_pkg::CNT_W'(1);
                     fc_in[s] = fc_new;
                     total_in = total_ff - ssa_pkg::TOTAL_W'(1);
                     wr_en    = 1'b1;
                     wr_addr  = {s, slot};
                     wr_data.in_use = 1'b1;
                     wr_data.link   = rd_ff.link;
                     if (fc_new == '0 && partial_ff[s]) begin
                        for (int t = 0; t < SN; t++) begin
                           if (partial_ff[t] && ssa_pkg::SLAB_W'(t) != s &&
                               rec_ff[t] > rec_ff[s]) begin
                              rec_in[t] = rec_ff[t] - ssa_pkg::REC_W'(1);
                           end
                        end
                        partial_in[s] = 1'b0;
                        rec_in[s]     = '0;
                     end
                     oslab_in = s;
                     oslot_in = slot;
                     off_in   = (prod > ssa_pkg::PROD_W'(ssa_pkg::OFF_MAX)) ?
                                ssa_pkg::OFF_MAX : prod[ssa_pkg::OFF_W-1:0];
                  end
               end else begin
                  good = active_ff[s] && ({1'b0, item_ff.slot} < size_ff[s]) &&
                         ({1'b0, item_ff.slot} < fresh_ff[s]) && rd_ff.in_use;
                  if (!good) begin
                     status_in = ssa_pkg::ST_BAD_FREE;
                  end else begin
                     status_in      = ssa_pkg::ST_OK;
                     wr_en          = 1'b1;
                     wr_addr        = {s, item_ff.slot};
                     wr_data.in_use = 1'b0;
                     wr_data.link   = head_ff[s];
                     head_in[s]     = item_ff.slot;
                     fc_new         = fc + ssa_pkg::CNT_W'(1);
                     fc_in[s]       = fc_new;
                     total_in       = total_ff + ssa_pkg::TOTAL_W'(1);
                     if (fc_new == size_ff[s]) begin
                        if (partial_ff[s]) begin
                           for (int t = 0; t < SN; t++) begin
                              if (partial_ff[t] && ssa_pkg::SLAB_W'(t) != s &&
                                  rec_ff[t] > rec_ff[s]) begin
                                 rec_in[t] = rec_ff[t] - ssa_pkg::REC_W'(1);
                              end
                           end
                           partial_in[s] = 1'b0;
                           rec_in[s]     = '0;
                        end
                        for (int t = 0; t < SN; t++) begin
                           if (ssa_pkg::SLAB_W'(t) != s && active_ff[t] &&
                               fc_ff[t] == size_ff[t]) begin
                              other_empty = 1'b1;
                           end
                        end
                        if (other_empty) begin
                           active_in[s] = 1'b0;
                           total_in     = total_ff + ssa_pkg::TOTAL_W'(1) -
                                          ssa_pkg::TOTAL_W'(size_ff[s]);
                           fc_in[s]     = '0;
                           head_in[s]   = '0;
                           if (cur_valid_ff && cur_ff == s) begin
                              cur_valid_in = 1'b0;
                           end
                        end
                     end else if (fc_new == ssa_pkg::CNT_W'(1)) begin
                        for (int t = 0; t < SN; t++) begin
                           if (partial_ff[t] && ssa_pkg::SLAB_W'(t) != s) begin
                              rec_in[t] = rec_ff[t] + ssa_pkg::REC_W'(1);
                           end
                        end
                        partial_in[s] = 1'b1;
                        rec_in[s]     = '0;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ssa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssa_pkg::S_IDLE;
         fail_ff      <= 1'b0;
         sel_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < SN; t++) begin
            active_ff[t]  <= 1'b0;
            partial_ff[t] <= 1'b0;
            rec_ff[t]     <= '0;
            head_ff[t]    <= '0;
            fc_ff[t]      <= '0;
            size_ff[t]    <= '0;
            fresh_ff[t]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fail_ff      <= fail_in;
         sel_ff       <= sel_in;
         cur_valid_ff <= cur_valid_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int t = 0; t < SN; t++) begin
            active_ff[t]  <= active_in[t];
            partial_ff[t] <= partial_in[t];
            rec_ff[t]     <= rec_in[t];
            head_ff[t]    <= head_in[t];
            fc_ff[t]      <= fc_in[t];
            size_ff[t]    <= size_in[t];
            fresh_ff[t]   <= fresh_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff   <= ssa_pkg::RESET_SLOTS;
         osize_ff <= ssa_pkg::RESET_OBJSIZE;
      end else if (csr_we) begin
         if (csr_index == ssa_pkg::CSR_SLOTS_PER_SLAB) begin
            spp_ff <= csr_wdata[ssa_pkg::CNT_W-1:0];
         end else begin
            osize_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      oslab_ff  <= oslab_in;
      oslot_ff  <= oslot_in;
      off_ff    <= off_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'd0, off_ff, oslot_ff, oslab_ff};

endmodule

[rtl/slab_slot_allocator.sv]
// slab slot allocator top level: intake queue and allocation engine
//
//   group  dir  width          contents
//   req_   in   tdata 16       free_slab, free_slot; tuser command
//   rsp_   out  tdata 32       slab_index, slot_index, byte_offset; tuser status
//   csr_   in   wdata 13       index 0 slots_per_slab, 1 object_size
//
// each item goes through the engine in steps: slab choice, link memory read, commit
// the intake queue holds two items, so requests are taken while the engine works
// the commit waits while a result is still held in the output register
// a newly opened slab is served from a per-slab fill count, so no clearing pass
// reset is synchronous and clears all bookkeeping at once
module slab_slot_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // free_slab, free_slot
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // slab_index, slot_index, byte_offset
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);

   logic q_valid;
   logic q_pop;
   ssa_pkg::item_type q_item;

   ssa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   ssa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
